/* hdl/rau_pkg.sv */
// Package: widths, operation codes and shared helpers for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WORD_BITS = 32;
  localparam int EXP_BITS  = 16;
  localparam int FUNC_BITS = 3;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [EXP_BITS-1:0]  exp_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_ABS = 3'd4,
    FN_POW = 3'd5
  } func_t;

  // Divider request and status between the sequencer and the divider.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

  function automatic word_t mag(input word_t v);
    mag = v[WORD_BITS-1] ? (~v + word_t'(1)) : v;
  endfunction
endpackage

/* hdl/rau_divider.sv */
// Radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);
  localparam int W = rau_pkg::WORD_BITS;

  logic                      busy_r, busy_nxt;
  logic [rau_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  rau_pkg::word_t            q_r, q_nxt, d_r, d_nxt;
  logic [W:0]                rem_r, rem_nxt;
  logic                      done_r, done_nxt;
  logic [W:0]                trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rau_pkg::CNT_BITS'(W);
      q_nxt    = req.dividend;
      d_nxt    = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (!trial[W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-1:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rau_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[W-1:0];

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) req.start |=> busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == rau_pkg::CNT_BITS'(1) |=> done_r)
    else $error("divider missed done");
endmodule

/* hdl/rational_arithmetic_unit_top.sv */
// Top level: sequencer for rational add/sub/mul/div/abs/power with gcd reduction.
`timescale 1ns / 1ps
//  channel | ports                                         | dir
//  in      | in_valid in_ready in_func in_a_num in_a_den    | in
//          | in_b_num in_b_den in_power                     |
//  out     | out_valid out_ready out_res_num out_res_den    | out
//          | out_zero_over_zero                             |
// One request at a time; in_ready is low from accept until the result is taken.
// Add, subtract, multiply and divide form their products in S_M0, S_M1 and S_M2 (one shared
// 32x32 multiplier, low word kept) before the reduction starts.
// A reduction runs Euclid on the shared radix-2 divider: a start state (S_RED), one divider
// run per remainder step (S_GCD), then one run each for the two quotients (S_QN, S_QD).
// A nonzero power reduces the base once, then repeats multiply-and-reduce |power| times.
// Reset (synchronous, rst_n low) clears the sequencer and out_valid; a stalled
// out_ready holds the result and no new request is taken meanwhile.
module rational_arithmetic_unit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rau_pkg::FUNC_BITS-1:0]    in_func,
  input  logic signed [rau_pkg::WORD_BITS-1:0] in_a_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0] in_a_den,
  input  logic signed [rau_pkg::WORD_BITS-1:0] in_b_num,
  input  logic signed [rau_pkg::WORD_BITS-1:0] in_b_den,
  input  logic signed [rau_pkg::EXP_BITS-1:0]  in_power,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rau_pkg::WORD_BITS-1:0] out_res_num,
  output logic signed [rau_pkg::WORD_BITS-1:0] out_res_den,
  output logic                             out_zero_over_zero
);
  localparam int W = rau_pkg::WORD_BITS;
  localparam int E = rau_pkg::EXP_BITS;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_M0   = 10'b0000000010, // an*bd, or an*bn for multiply and power
    S_M1   = 10'b0000000100, // bn*ad
    S_M2   = 10'b0000001000, // den product, form reduce inputs
    S_RED  = 10'b0000010000, // start reduction
    S_GCD  = 10'b0000100000, // Euclid step through divider
    S_QN   = 10'b0001000000, // nmag / g
    S_QD   = 10'b0010000000, // dmag / g
    S_FIN  = 10'b0100000000, // reduction done: power bookkeeping
    S_DONE = 10'b1000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [rau_pkg::FUNC_BITS-1:0] func_r, func_nxt;
  // operands; for power an/ad hold the running product and bn/bd the base
  rau_pkg::word_t an_r, ad_r, bn_r, bd_r;
  rau_pkg::word_t an_nxt, ad_nxt, bn_nxt, bd_nxt;
  rau_pkg::word_t p0_r, p0_nxt, p1_r, p1_nxt;
  // reduction operands: magnitudes and signs
  rau_pkg::word_t nmag_r, nmag_nxt, dmag_r, dmag_nxt;
  logic           nneg_r, nneg_nxt, dneg_r, dneg_nxt;
  rau_pkg::word_t gx_r, gx_nxt, gy_r, gy_nxt, qn_r, qn_nxt;
  rau_pkg::exp_t  cnt_r, cnt_nxt;    // power: multiplies left
  logic           base_r, base_nxt;  // current reduction is the power base
  logic           negpw_r, negpw_nxt;
  logic           zz_r, zz_nxt;
  rau_pkg::word_t rn_r, rn_nxt, rd_r, rd_nxt;
  logic           ov_r, ov_nxt;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;
  rau_pkg::word_t mul_x, mul_y, mul_p, num_w;
  rau_pkg::exp_t  pw;

  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // single shared multiplier, low word kept
  assign mul_p = rau_pkg::word_t'(mul_x * mul_y);
  assign pw    = in_power;

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;  func_nxt = func_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    p0_nxt = p0_r; p1_nxt = p1_r;
    nmag_nxt = nmag_r; dmag_nxt = dmag_r; nneg_nxt = nneg_r; dneg_nxt = dneg_r;
    gx_nxt = gx_r; gy_nxt = gy_r; qn_nxt = qn_r;
    cnt_nxt = cnt_r; base_nxt = base_r; negpw_nxt = negpw_r;
    zz_nxt = zz_r; rn_nxt = rn_r; rd_nxt = rd_r; ov_nxt = ov_r;
    mul_x = an_r; mul_y = bd_r; num_w = p0_r;
    dreq.start = 1'b0; dreq.dividend = gx_r; dreq.divisor = gy_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          func_nxt = in_func;
          an_nxt = in_a_num; ad_nxt = in_a_den;
          bn_nxt = in_b_num; bd_nxt = in_b_den;
          zz_nxt = 1'b0; base_nxt = 1'b0;
          negpw_nxt = pw[E-1];
          // most negative exponent negates to itself, read as unsigned
          cnt_nxt = pw[E-1] ? (rau_pkg::exp_t'(0) - pw) : pw;
          state_nxt = S_DONE;
          unique case (in_func)
            rau_pkg::FN_ADD, rau_pkg::FN_SUB, rau_pkg::FN_MUL, rau_pkg::FN_DIV: begin
              state_nxt = S_M0;
            end
            rau_pkg::FN_ABS: begin
              nneg_nxt = 1'b0; dneg_nxt = 1'b0;
              nmag_nxt = rau_pkg::mag(in_a_num); dmag_nxt = rau_pkg::mag(in_a_den);
              state_nxt = S_RED;
            end
            rau_pkg::FN_POW: begin
              if (pw == '0) begin
                rn_nxt = rau_pkg::word_t'(1); rd_nxt = rau_pkg::word_t'(1);
              end else begin
                base_nxt = 1'b1;
                nneg_nxt = in_a_num[W-1]; nmag_nxt = rau_pkg::mag(in_a_num);
                dneg_nxt = in_a_den[W-1]; dmag_nxt = rau_pkg::mag(in_a_den);
                state_nxt = S_RED;
              end
            end
            default: begin
              rn_nxt = '0; rd_nxt = '0;
            end
          endcase
        end
      end
      S_M0: begin
        mul_x = an_r;
        mul_y = (func_r == rau_pkg::FN_MUL || func_r == rau_pkg::FN_POW) ? bn_r : bd_r;
        p0_nxt = mul_p;
        state_nxt = S_M1;
      end
      S_M1: begin
        mul_x = bn_r; mul_y = ad_r;
        p1_nxt = mul_p;
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_x = ad_r;
        mul_y = (func_r == rau_pkg::FN_DIV) ? bn_r : bd_r;
        unique case (func_r)
          rau_pkg::FN_ADD: num_w = p0_r + p1_r;
          rau_pkg::FN_SUB: num_w = p0_r - p1_r;
          default:         num_w = p0_r;
        endcase
        nneg_nxt = num_w[W-1]; nmag_nxt = rau_pkg::mag(num_w);
        dneg_nxt = mul_p[W-1]; dmag_nxt = rau_pkg::mag(mul_p);
        state_nxt = S_RED;
      end
      S_RED: begin
        gx_nxt = nmag_r; gy_nxt = dmag_r;
        state_nxt = S_GCD;
        if (dmag_r != '0) begin
          dreq.start = 1'b1; dreq.dividend = nmag_r; dreq.divisor = dmag_r;
        end
      end
      S_GCD: begin
        // gx holds x, gy holds y; step only while y is nonzero
        if (gy_r == '0) begin
          if (gx_r == '0) begin
            zz_nxt = 1'b1;
            rn_nxt = '0; rd_nxt = '0;
            state_nxt = S_FIN;
          end else begin
            dreq.start = 1'b1; dreq.dividend = nmag_r; dreq.divisor = gx_r;
            state_nxt = S_QN;
          end
        end else if (drsp.done) begin
          gx_nxt = gy_r; gy_nxt = drsp.rem;
          if (drsp.rem != '0) begin
            dreq.start = 1'b1; dreq.dividend = gy_r; dreq.divisor = drsp.rem;
          end
        end
      end
      S_QN: begin
        if (drsp.done) begin
          qn_nxt = drsp.quot;
          dreq.start = 1'b1; dreq.dividend = dmag_r; dreq.divisor = gx_r;
          state_nxt = S_QD;
        end
      end
      S_QD: begin
        if (drsp.done) begin
          rn_nxt = (nneg_r ^ dneg_r) ? (rau_pkg::word_t'(0) - qn_r) : qn_r;
          rd_nxt = drsp.quot;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        priority if (func_r != rau_pkg::FN_POW) begin
          state_nxt = S_DONE;
        end else if (base_r) begin
          // reduced base, swapped for a negative exponent; start from 1/1
          base_nxt = 1'b0;
          an_nxt = rau_pkg::word_t'(1); ad_nxt = rau_pkg::word_t'(1);
          bn_nxt = negpw_r ? rd_r : rn_r;
          bd_nxt = negpw_r ? rn_r : rd_r;
          state_nxt = S_M0;
        end else begin
          an_nxt = rn_r; ad_nxt = rd_r;
          cnt_nxt = cnt_r - rau_pkg::exp_t'(1);
          state_nxt = (cnt_r == rau_pkg::exp_t'(1)) ? S_DONE : S_M0;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    func_r <= func_nxt; negpw_r <= negpw_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    p0_r <= p0_nxt; p1_r <= p1_nxt;
    nmag_r <= nmag_nxt; dmag_r <= dmag_nxt; nneg_r <= nneg_nxt; dneg_r <= dneg_nxt;
    gx_r <= gx_nxt; gy_r <= gy_nxt; qn_r <= qn_nxt;
    cnt_r <= cnt_nxt; base_r <= base_nxt;
    zz_r <= zz_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
  end

  assign out_valid          = ov_r;
  assign out_res_num        = rn_r;
  assign out_res_den        = rd_r;
  assign out_zero_over_zero = zz_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("request accepted without start");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num))
    else $error("result dropped under stall");
endmodule

/* tb/tb.sv */
// Testbench for the rational arithmetic unit: random and directed requests checked per result.
`timescale 1ns / 1ps
// Method:
//   - An initial block fills a queue of pending requests.
//     It starts with a short directed list: operand extremes, every opcode,
//     zero over zero, zero, negative and minimum exponents, and undefined opcodes.
//     Then it adds random requests with mixed operand classes.
//   - A driver at the falling edge offers requests in bursts with random gaps.
//   - The receiver stalls on its own pattern, with one long hold-off.
//   - At every accepted request, a predictor written in SystemVerilog computes
//     the reduced rational and queues it. The monitor compares each accepted
//     result with the oldest queued one.
module tb;
  localparam logic [rau_pkg::FUNC_BITS-1:0] FN_UNDEF_LO = 3'd6;
  localparam logic [rau_pkg::FUNC_BITS-1:0] FN_UNDEF_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1880;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int LONG_HOLD = 3000;
  localparam int HOLD_AT = 300;

  typedef struct {
    logic [rau_pkg::FUNC_BITS-1:0] func;
    rau_pkg::word_t an, ad, bn, bd;
    rau_pkg::exp_t  pw;
    bit    drain;          // wait until every result is back before sending
  } rat_req_t;

  typedef struct {
    rau_pkg::word_t num, den;
    bit    zz;
  } rat_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rau_pkg::FUNC_BITS-1:0] in_func = '0;
  logic signed [rau_pkg::WORD_BITS-1:0] in_a_num = '0, in_a_den = '0;
  logic signed [rau_pkg::WORD_BITS-1:0] in_b_num = '0, in_b_den = '0;
  logic signed [rau_pkg::EXP_BITS-1:0] in_power = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [rau_pkg::WORD_BITS-1:0] out_res_num, out_res_den;
  logic out_zero_over_zero;

  rat_req_t pending_q[$];
  rat_res_t reduced_q[$];
  int  mismatches = 0;
  int  accepted_reqs = 0;
  int  checked_results = 0;
  int  zz_results = 0;
  int  pow_reqs = 0;
  longint cycles = 0;
  bit  taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  rational_arithmetic_unit_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num),
    .in_b_den(in_b_den), .in_power(in_power),
    .out_valid(out_valid), .out_ready(out_ready), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_zero_over_zero(out_zero_over_zero)
  );

  // 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic rau_pkg::word_t unsigned_mag(rau_pkg::word_t v);
    return v[rau_pkg::WORD_BITS-1] ? (rau_pkg::word_t'(0) - v) : v;
  endfunction

  // Euclid on unsigned magnitudes; g == 0 only for 0/0.
  function automatic rat_res_t reduce_mag(bit nneg, rau_pkg::word_t nm, bit dneg,
                                          rau_pkg::word_t dm, inout bit zz);
    rau_pkg::word_t x, y, t, qn, qd;
    rat_res_t r;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    r.zz = 1'b0;
    if (x == 0) begin
      zz = 1'b1;
      r.num = '0;
      r.den = '0;
      return r;
    end
    qn = nm / x;
    qd = dm / x;
    if (dneg) nneg = !nneg;
    r.num = nneg ? (rau_pkg::word_t'(0) - qn) : qn;
    r.den = qd;
    return r;
  endfunction

  function automatic rat_res_t reduce_signed(rau_pkg::word_t n, rau_pkg::word_t d,
                                             inout bit zz);
    return reduce_mag(n[rau_pkg::WORD_BITS-1], unsigned_mag(n),
                      d[rau_pkg::WORD_BITS-1], unsigned_mag(d), zz);
  endfunction

  function automatic rat_res_t reduced_result(rat_req_t q);
    rat_res_t r, base;
    bit zz;
    rau_pkg::word_t t;
    rau_pkg::exp_t neg;
    int count;
    zz = 1'b0;
    r.num = '0;
    r.den = '0;
    case (q.func)
      rau_pkg::FN_ADD: r = reduce_signed(q.an * q.bd + q.bn * q.ad, q.ad * q.bd, zz);
      rau_pkg::FN_SUB: r = reduce_signed(q.an * q.bd - q.bn * q.ad, q.ad * q.bd, zz);
      rau_pkg::FN_MUL: r = reduce_signed(q.an * q.bn, q.ad * q.bd, zz);
      rau_pkg::FN_DIV: r = reduce_signed(q.an * q.bd, q.ad * q.bn, zz);
      rau_pkg::FN_ABS: r = reduce_mag(1'b0, unsigned_mag(q.an), 1'b0, unsigned_mag(q.ad), zz);
      rau_pkg::FN_POW: begin
        r.num = rau_pkg::word_t'(1);
        r.den = rau_pkg::word_t'(1);
        if (q.pw != 0) begin
          base = reduce_signed(q.an, q.ad, zz);
          if (q.pw[rau_pkg::EXP_BITS-1]) begin
            // Invert the reduced base; the most negative exponent keeps full magnitude.
            t = base.num;
            base.num = base.den;
            base.den = t;
            neg = rau_pkg::exp_t'(0) - q.pw;
            count = (neg == 0) ? (1 << (rau_pkg::EXP_BITS - 1)) : int'(neg);
          end else begin
            count = int'(q.pw);
          end
          for (int i = 0; i < count; i++)
            r = reduce_signed(r.num * base.num, r.den * base.den, zz);
        end
      end
      default: ;
    endcase
    r.zz = zz;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic rau_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return rau_pkg::word_t'(1);
      4: return '1;
      5, 6: return rau_pkg::word_t'($urandom_range(0, 40)) - rau_pkg::word_t'(20);
      7: return rau_pkg::word_t'($urandom_range(0, 4000)) - rau_pkg::word_t'(2000);
      default: return rau_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [rau_pkg::FUNC_BITS-1:0] f, int an, int ad, int bn,
                         int bd, int pw, bit drain);
    rat_req_t q;
    q.func = f;
    q.an = rau_pkg::word_t'(an); q.ad = rau_pkg::word_t'(ad);
    q.bn = rau_pkg::word_t'(bn); q.bd = rau_pkg::word_t'(bd);
    q.pw = rau_pkg::exp_t'(pw); q.drain = drain;
    pending_q.push_back(q);
  endtask

  initial begin
    rat_req_t q;
    // Directed part.
    add_req(rau_pkg::FN_ADD, 1, 2, 1, 3, 0, 0);
    add_req(rau_pkg::FN_SUB, 1, 2, 1, 3, 0, 0);
    add_req(rau_pkg::FN_MUL, -6, 4, 10, -3, 0, 0);
    add_req(rau_pkg::FN_DIV, 3, 4, -9, 8, 0, 0);
    add_req(rau_pkg::FN_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            0, 0);
    add_req(rau_pkg::FN_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0);
    add_req(rau_pkg::FN_ADD, 0, 0, 0, 0, 0, 0);              // zero over zero
    add_req(rau_pkg::FN_DIV, 5, 7, 0, 3, 0, 0);              // divide by zero numerator
    add_req(rau_pkg::FN_ABS, 32'h8000_0000, -1, 0, 0, 0, 0); // abs of the most negative value
    add_req(rau_pkg::FN_ABS, -12, 32'h8000_0000, -1, -1, 0, 0);
    add_req(rau_pkg::FN_ABS, 0, 0, 0, 0, 0, 0);
    add_req(rau_pkg::FN_POW, 32'h8000_0000, 3, 0, 0, 0, 0);  // zero exponent
    add_req(rau_pkg::FN_POW, 2, 3, 0, 0, 5, 0);
    add_req(rau_pkg::FN_POW, -2, 3, 0, 0, -3, 0);            // negative exponent
    add_req(rau_pkg::FN_POW, 0, 0, 0, 0, 2, 0);
    add_req(rau_pkg::FN_POW, 1, 1, 0, 0, 16'h8000, 1);       // most negative exponent
    add_req(rau_pkg::FN_POW, -1, 1, 0, 0, 16'h7fff, 0);
    add_req(FN_UNDEF_LO, 3, 4, 5, 6, 7, 0);
    add_req(FN_UNDEF_HI, -1, -1, -1, -1, -1, 0);
    add_req(rau_pkg::FN_SUB, -1, 32'h7fff_ffff, 32'h7fff_ffff, -1, -1, 1);
    // Random part: powers are rare and mostly small, since each step is a reduction.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      q.an = pick_word(); q.ad = pick_word(); q.bn = pick_word(); q.bd = pick_word();
      q.pw = rau_pkg::exp_t'($urandom);
      q.drain = ($urandom_range(0, 199) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: q.func = rau_pkg::FN_ADD;
        4, 5, 6, 7: q.func = rau_pkg::FN_SUB;
        8, 9, 10, 11: q.func = rau_pkg::FN_MUL;
        12, 13, 14, 15: q.func = rau_pkg::FN_DIV;
        16, 17: q.func = rau_pkg::FN_ABS;
        18: begin
          q.func = rau_pkg::FN_POW;
          q.pw = rau_pkg::exp_t'($urandom_range(0, 10)) - rau_pkg::exp_t'(5);
        end
        default: q.func = ($urandom_range(0, 1) != 0) ? FN_UNDEF_LO : FN_UNDEF_HI;
      endcase
      add_req(q.func, int'(q.an), int'(q.ad), int'(q.bn), int'(q.bd),
              int'($signed(q.pw)), q.drain);
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Let the driver empty the queue, then collect every result.
    wait (pending_q.size() == 0 && !in_valid);
    wait (reduced_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d requests (%0d power), %0d results checked, %0d zero-over-zero",
             accepted_reqs, pow_reqs, checked_results, zz_results);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("PASS rational_arithmetic_unit_top");
    end else begin
      $display("mismatches: %0d, results still expected: %0d", mismatches, reduced_q.size());
      $display("FAIL rational_arithmetic_unit_top");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  // Hold a request until it is taken; then advance, honoring bursts, gaps and drain marks.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0 && !(pending_q[0].drain && reduced_q.size() > 0)) begin
        in_func  <= pending_q[0].func;
        in_a_num <= pending_q[0].an;
        in_a_den <= pending_q[0].ad;
        in_b_num <= pending_q[0].bn;
        in_b_den <= pending_q[0].bd;
        in_power <= pending_q[0].pw;
        in_valid <= 1'b1;
        void'(pending_q.pop_front());
        if (burst_left == 0) begin
          burst_left <= int'($urandom_range(1, 20));
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // One long hold-off at HOLD_AT accepted requests; else a three-phase stall pattern.
  always @(negedge clk) begin
    if (!hold_done && accepted_reqs == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ((cycles / 5000) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, rau_pkg::word_t got, rau_pkg::word_t want);
    mismatches++;
    $display("mismatch #%0d at cycle %0d: %s got %h want %h", mismatches, cycles, what, got,
             want);
  endtask

  always @(posedge clk) begin
    rat_req_t q;
    rat_res_t want;
    cycles <= cycles + 1;
    taken  <= rst_n && in_valid && in_ready;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rational_arithmetic_unit_top");
      $finish;
    end else if (rst_n) begin
      // Predict on request acceptance.
      if (in_valid && in_ready) begin
        q.func = in_func; q.an = in_a_num; q.ad = in_a_den;
        q.bn = in_b_num; q.bd = in_b_den; q.pw = in_power; q.drain = 1'b0;
        reduced_q.push_back(reduced_result(q));
        accepted_reqs++;
        if (in_func == rau_pkg::FN_POW) pow_reqs++;
      end
      // Check on result acceptance.
      if (out_valid && out_ready) begin
        if (reduced_q.size() == 0) begin
          report_mismatch("unexpected result", out_res_num, '0);
        end else begin
          want = reduced_q.pop_front();
          checked_results++;
          if (want.zz) zz_results++;
          if (out_res_num !== want.num) report_mismatch("res_num", out_res_num, want.num);
          if (out_res_den !== want.den) report_mismatch("res_den", out_res_den, want.den);
          if (out_zero_over_zero !== want.zz)
            report_mismatch("zero_over_zero", rau_pkg::word_t'(out_zero_over_zero),
                            rau_pkg::word_t'(want.zz));
        end
      end
    end
  end
endmodule

/* sim.f */
hdl/rau_pkg.sv
hdl/rau_divider.sv
hdl/rational_arithmetic_unit_top.sv
tb/tb.sv
